@@ design/pbrw_pkg.sv @@
// ============================================================================
// pbrw_pkg: shared types and constants for the base relocation walker
// Holds the error codes, the field widths and the result struct that travels
// from the walker core to the output register.
// ============================================================================
package pbrw_pkg;

  localparam int unsigned WORD_W     = 32;
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned OFFSET_W   = 12;
  localparam int unsigned TYPE_W     = 4;
  localparam int unsigned PATCH_W    = WORD_W + 1;
  localparam int unsigned HDR_BYTES  = 8;
  localparam int unsigned HDR_CNT_W  = 3;

  // Entry types (upper nibble of a 16-bit entry)
  localparam logic [TYPE_W-1:0] TYPE_ABSOLUTE = 4'd0;
  localparam logic [TYPE_W-1:0] TYPE_DIR64    = 4'd10;

  // Configuration register indexes
  localparam logic CFG_DIRECTORY_SIZE = 1'b0;
  localparam logic CFG_IMAGE_SIZE     = 1'b1;

  typedef enum logic [1:0] {
    ERR_NONE       = 2'd0,
    ERR_BLOCK_SIZE = 2'd1,
    ERR_OUTSIDE    = 2'd2,
    ERR_TYPE       = 2'd3
  } err_code_t;

  typedef struct packed {
    logic               patch_valid;
    logic [PATCH_W-1:0] patch_offset;
    err_code_t          error_code;
    logic               done_res;
  } result_t;

endpackage

@@ design/pe_base_relocation_walker_top.sv @@
// ============================================================================
// pe_base_relocation_walker_top: PE base relocation directory walker
// Streams the relocation directory a byte at a time and reports dir64 patch
// offsets, a sticky error code and directory completion for every byte.
// ============================================================================
//
//  channel | handshake            | payload
//  --------+----------------------+------------------------------------------
//  in      | in_valid / in_stall  | data_byte
//  out     | out_valid / out_stall| patch_valid, patch_offset, error_code,
//          |                      | done_res
//  cfg     | cfg_we               | cfg_index, cfg_data
//
//  One beat in, one beat out. A byte lands in the input register, is parsed
//  by the walker core once the output register is free, and its result is
//  written to the output register. One byte per cycle is sustained while
//  out_stall is low, and the walker core's state update sets that rate.
//  Synchronous reset returns the walker to expecting a block header with no
//  error and both size registers at zero. A stalled output holds its beat; the
//  input register then fills and in_stall rises until the output drains.
//
module pe_base_relocation_walker_top (
  input  logic                                clk,
  input  logic                                rst,
  // byte input channel
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [pbrw_pkg::BYTE_W-1:0]         data_byte,
  // result channel
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                patch_valid,
  output logic [pbrw_pkg::PATCH_W-1:0]        patch_offset,
  output logic [1:0]                          error_code,
  output logic                                done_res,
  // configuration writes
  input  logic                                cfg_we,
  input  logic                                cfg_index,
  input  logic [pbrw_pkg::WORD_W-1:0]         cfg_data
);
  import pbrw_pkg::*;

  logic [WORD_W-1:0] directory_size;
  logic [WORD_W-1:0] image_size;

  // input register
  logic              s1_valid;
  logic [BYTE_W-1:0] s1_byte;

  // output register
  result_t           out_res;
  result_t           walk_res;

  logic              out_free;   // output register can take a new beat
  logic              in_take;    // input beat accepted
  logic              s1_fire;    // held byte goes through the walker

  assign out_free = !out_valid || !out_stall;
  assign s1_fire  = s1_valid && out_free;
  assign in_stall = s1_valid && !out_free;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      directory_size <= '0;
      image_size     <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_DIRECTORY_SIZE: directory_size <= cfg_data;
        CFG_IMAGE_SIZE:     image_size     <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_take) begin
      s1_valid <= 1'b1;
    end else if (s1_fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_byte <= data_byte;
    end
  end

  pbrw_walk u_walk (
    .clk            (clk),
    .rst            (rst),
    .go             (s1_fire),
    .data_byte      (s1_byte),
    .directory_size (directory_size),
    .image_size     (image_size),
    .res            (walk_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s1_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_res <= walk_res;
    end
  end

  assign patch_valid  = out_res.patch_valid;
  assign patch_offset = out_res.patch_offset;
  assign error_code   = out_res.error_code;
  assign done_res     = out_res.done_res;

  // a delivered patch never carries an error
  a_patch_no_err: assert property (@(posedge clk) disable iff (rst)
    out_valid && patch_valid |-> error_code == ERR_NONE)
    else $error("patch beat with error code set");

  // completion is only reported on a clean walk
  a_done_no_err: assert property (@(posedge clk) disable iff (rst)
    out_valid && done_res |-> error_code == ERR_NONE)
    else $error("done beat with error code set");

  // input back-pressure only comes from a blocked output register
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall && s1_valid)
    else $error("input stalled while output can drain");

  // once an error is delivered, the next delivered beat keeps it
  a_err_sticky: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && error_code != ERR_NONE && s1_valid |=>
      out_valid && error_code == $past(error_code))
    else $error("sticky error code changed");

endmodule

@@ design/pbrw_walk.sv @@
// ============================================================================
// pbrw_walk: relocation directory parser core
// Holds the walk state and turns one directory byte into the next state and
// one result, combinationally.
// ============================================================================
module pbrw_walk (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          go,
  input  logic [pbrw_pkg::BYTE_W-1:0]   data_byte,
  input  logic [pbrw_pkg::WORD_W-1:0]   directory_size,
  input  logic [pbrw_pkg::WORD_W-1:0]   image_size,
  output pbrw_pkg::result_t             res
);
  import pbrw_pkg::*;

  logic                   in_header,         in_header_next;
  logic [HDR_CNT_W-1:0]   header_byte_count, header_byte_count_next;
  logic [WORD_W-1:0]      page_address,      page_address_next;
  logic [WORD_W-1:0]      block_bytes,       block_bytes_next;
  logic [WORD_W-1:0]      block_position,    block_position_next;
  logic [WORD_W-1:0]      total_consumed,    total_consumed_next;
  logic [BYTE_W-1:0]      held_low_byte,     held_low_byte_next;
  err_code_t              sticky_error,      sticky_error_next;

  logic                   finished;
  logic                   active;
  logic [WORD_W-1:0]      block_start;
  logic [PATCH_W-1:0]     block_end;
  logic [WORD_W-1:0]      pos_inc;
  logic [TYPE_W-1:0]      entry_type;
  logic [OFFSET_W-1:0]    entry_offset;
  logic [PATCH_W-1:0]     target;

  assign finished = (sticky_error == ERR_NONE) && in_header &&
                    (header_byte_count == '0) && (total_consumed == directory_size);
  assign active   = go && (sticky_error == ERR_NONE) && !finished;

  assign block_start  = total_consumed_next - WORD_W'(HDR_BYTES);
  assign block_end    = {1'b0, block_start} + {1'b0, block_bytes_next};
  assign pos_inc      = block_position + WORD_W'(1);
  assign entry_type   = data_byte[BYTE_W-1 -: TYPE_W];
  assign entry_offset = {data_byte[OFFSET_W-BYTE_W-1:0], held_low_byte};
  assign target       = {1'b0, page_address} + PATCH_W'(entry_offset);

  always_comb begin
    in_header_next         = in_header;
    header_byte_count_next = header_byte_count;
    page_address_next      = page_address;
    block_bytes_next       = block_bytes;
    block_position_next    = block_position;
    total_consumed_next    = total_consumed;
    held_low_byte_next     = held_low_byte;
    sticky_error_next      = sticky_error;
    res.patch_valid        = 1'b0;
    res.patch_offset       = '0;

    if (active) begin
      total_consumed_next = total_consumed + WORD_W'(1);
      if (in_header) begin
        // bytes 0..3 page address, 4..7 block size, little endian
        unique case (header_byte_count[1:0])
          2'd0: begin
            if (header_byte_count[2]) block_bytes_next[7:0]  = data_byte;
            else                      page_address_next[7:0] = data_byte;
          end
          2'd1: begin
            if (header_byte_count[2]) block_bytes_next[15:8]  = data_byte;
            else                      page_address_next[15:8] = data_byte;
          end
          2'd2: begin
            if (header_byte_count[2]) block_bytes_next[23:16]  = data_byte;
            else                      page_address_next[23:16] = data_byte;
          end
          default: begin
            if (header_byte_count[2]) block_bytes_next[31:24]  = data_byte;
            else                      page_address_next[31:24] = data_byte;
          end
        endcase
        if (header_byte_count == HDR_CNT_W'(HDR_BYTES - 1)) begin
          header_byte_count_next = '0;
          if ((block_bytes_next < WORD_W'(HDR_BYTES)) ||
              (block_end > {1'b0, directory_size})) begin
            sticky_error_next = ERR_BLOCK_SIZE;
          end else begin
            block_position_next = WORD_W'(HDR_BYTES);
            in_header_next      = (block_bytes_next == WORD_W'(HDR_BYTES));
          end
        end else begin
          header_byte_count_next = header_byte_count + HDR_CNT_W'(1);
        end
      end else begin
        // entries start at an even offset, so parity of position picks the half
        if (!block_position[0]) begin
          if (pos_inc != block_bytes) held_low_byte_next = data_byte;
        end else if (entry_type == TYPE_DIR64) begin
          if (target >= {1'b0, image_size}) begin
            sticky_error_next = ERR_OUTSIDE;
          end else begin
            res.patch_valid  = 1'b1;
            res.patch_offset = target;
          end
        end else if (entry_type != TYPE_ABSOLUTE) begin
          sticky_error_next = ERR_TYPE;
        end
        block_position_next = pos_inc;
        if ((sticky_error_next == ERR_NONE) && (pos_inc == block_bytes)) begin
          in_header_next         = 1'b1;
          header_byte_count_next = '0;
        end
      end
    end

    res.error_code = sticky_error_next;
    res.done_res   = (sticky_error_next == ERR_NONE) && in_header_next &&
                     (header_byte_count_next == '0) &&
                     (total_consumed_next == directory_size);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_header         <= 1'b1;
      header_byte_count <= '0;
      page_address      <= '0;
      block_bytes       <= '0;
      block_position    <= '0;
      total_consumed    <= '0;
      held_low_byte     <= '0;
      sticky_error      <= ERR_NONE;
    end else begin
      in_header         <= in_header_next;
      header_byte_count <= header_byte_count_next;
      page_address      <= page_address_next;
      block_bytes       <= block_bytes_next;
      block_position    <= block_position_next;
      total_consumed    <= total_consumed_next;
      held_low_byte     <= held_low_byte_next;
      sticky_error      <= sticky_error_next;
    end
  end

endmodule
